// ===== rtl/core/gsg_pkg.sv =====
`timescale 1ns / 1ps

package gsg_pkg;

  // Field and datapath widths.
  localparam int ANGLE_W    = 25;
  localparam int STICK_W    = 11;
  localparam int LIM_W      = 9;
  localparam int SWEEP_W    = 33;
  localparam int INC_W      = 13;
  localparam int GAIN_W     = 19;
  localparam int PROD_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int NUM_REGS   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int IN_DATA_W  = 176;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_USER_W = 2;

  typedef enum logic [1:0] {
    MODE_SLEEP = 2'd0,
    MODE_RC    = 2'd1,
    MODE_PC    = 2'd2,
    MODE_DEBUG = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    LOOP_OFF = 2'd0,
    LOOP_RC  = 2'd1,
    LOOP_PC  = 2'd2
  } loop_sel_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PITCH_MAX       = 3'd0,
    REG_PITCH_MIN       = 3'd1,
    REG_YAW_MAX         = 3'd2,
    REG_YAW_MIN         = 3'd3,
    REG_SWEEP_PITCH_MAX = 3'd4,
    REG_SWEEP_PITCH_MIN = 3'd5,
    REG_SWEEP_YAW_MAX   = 3'd6,
    REG_SWEEP_YAW_MIN   = 3'd7
  } reg_idx_e;

  localparam logic signed [LIM_W-1:0] REG_RESET [NUM_REGS] = '{
    9'sd20, -9'sd35, 9'sd60, -9'sd60, 9'sd20, -9'sd40, 9'sd65, -9'sd65
  };

  // Stick centre, per-count gains (degrees per count scaled by 2^32) and patrol steps.
  localparam logic signed [STICK_W:0]   STICK_CENTRE = 12'sd1024;
  localparam logic signed [GAIN_W-1:0]  GAIN_PITCH   = 19'sd214748;
  localparam logic signed [GAIN_W-1:0]  GAIN_YAW     = 19'sd171799;
  localparam logic signed [SWEEP_W-1:0] STEP_PITCH   = 33'sd2294;
  localparam logic signed [SWEEP_W-1:0] STEP_YAW     = 33'sd1966;
  localparam logic signed [PROD_W-1:0]  ROUND_HALF   = 32'sd32768;

  // Patrol values saturate at the 32-bit signed range.
  localparam logic signed [SWEEP_W-1:0] SWEEP_TOP    = 33'sd2147483647;
  localparam logic signed [SWEEP_W-1:0] SWEEP_BOT    = -33'sd2147483648;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [SWEEP_W-1:0] sweep_t;
  typedef logic signed [INC_W-1:0]   inc_t;

  typedef struct packed {
    angle_t pitch_max;
    angle_t pitch_min;
    angle_t yaw_max;
    angle_t yaw_min;
  } limits_t;

  // One decoded tick as held in the input register.
  typedef struct packed {
    mode_e  mode;
    logic   target_locked;
    logic   partner_valid;
    inc_t   inc_pitch;
    inc_t   inc_yaw;
    angle_t measured_yaw;
    angle_t measured_pitch;
    angle_t vision_yaw;
    angle_t vision_pitch;
    angle_t partner_yaw;
    angle_t partner_pitch;
  } item_t;

  typedef struct packed {
    logic en;
    logic changed;
  } tick_t;

  // Sign extension of an angle into the wider working width.
  function automatic sweep_t widen(angle_t a);
    return sweep_t'(a);
  endfunction

  // Whole degrees to 1/65536 degree.
  function automatic angle_t lim_deg(logic signed [LIM_W-1:0] d);
    return angle_t'({d, {FRAC_W{1'b0}}});
  endfunction

  // Limit to [mn, mx]; if they cross, x >= mx gives mx and any other x gives mn.
  function automatic sweep_t clamp(sweep_t x, sweep_t mx, sweep_t mn);
    sweep_t r;
    if (x >= mx) begin
      r = mx;
    end else if (x <= mn) begin
      r = mn;
    end else begin
      r = x;
    end
    return r;
  endfunction

  // Stick offset times gain, rounded to nearest with ties away from zero.
  function automatic inc_t stick_step(logic [STICK_W-1:0] stick,
                                      logic signed [GAIN_W-1:0] gain);
    logic signed [STICK_W:0]   off;
    logic signed [PROD_W-1:0]  p;
    logic signed [PROD_W-1:0]  mag;
    logic signed [PROD_W-1:0]  q;
    off = $signed({1'b0, stick}) - STICK_CENTRE;
    p   = PROD_W'(off) * PROD_W'(gain);
    mag = p[PROD_W-1] ? -p : p;
    q   = (mag + ROUND_HALF) >>> FRAC_W;
    return p[PROD_W-1] ? INC_W'(-q) : INC_W'(q);
  endfunction

endpackage

// ===== rtl/core/gimbal_setpoint_generator.sv =====
`timescale 1ns / 1ps
// Pipeline: two register stages (input register, result register). The setpoint integrators
// close their loop combinationally through their own registers.
// Throughput: one tick per cycle unless the result register is full and not being taken.
// The input side stalls only while the result register is full and not being taken.
// Reset (asynchronous, active low) empties both registers, zeroes the RC setpoint and patrol
// state, sets the previous mode to sleep and loads the limit registers with their defaults.
module gimbal_setpoint_generator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input ticks.
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata from bit 0: stick_yaw, stick_pitch, measured_yaw, measured_pitch,
  // vision_yaw, vision_pitch, partner_yaw, partner_pitch, zero padding.
  input  logic [gsg_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // tuser from bit 0: mode, target_locked, partner_valid.
  input  logic [gsg_pkg::IN_USER_W-1:0]     s_axis_tuser_i,
  // Setpoint results.
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // tdata from bit 0: pitch_setpoint, yaw_setpoint, zero padding.
  output logic [gsg_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // tuser from bit 0: loop_select.
  output logic [gsg_pkg::OUT_USER_W-1:0]    m_axis_tuser_o,
  // Limit register writes.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gsg_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [gsg_pkg::LIM_W-1:0]         cfg_data_i
);

  logic signed [gsg_pkg::LIM_W-1:0] cfg_q [gsg_pkg::NUM_REGS];

  logic              s1_valid, advance;
  gsg_pkg::item_t    s1_item;
  gsg_pkg::mode_e    prev_mode_q;
  gsg_pkg::tick_t    rc_tick, pc_tick;
  gsg_pkg::limits_t  rc_lim, pc_lim;
  gsg_pkg::angle_t   rc_pitch, rc_yaw, pc_pitch, pc_yaw;

  logic                 out_valid_q;
  gsg_pkg::angle_t      out_pitch_q, out_pitch_d;
  gsg_pkg::angle_t      out_yaw_q, out_yaw_d;
  gsg_pkg::loop_sel_e   out_sel_q, out_sel_d;

  // Limit registers accept a write in every cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= gsg_pkg::REG_RESET;
    end else if (cfg_valid_i) begin
      cfg_q[cfg_index_i] <= $signed(cfg_data_i);
    end
  end

  always_comb begin
    rc_lim.pitch_max = gsg_pkg::lim_deg(cfg_q[gsg_pkg::REG_PITCH_MAX]);
    rc_lim.pitch_min = gsg_pkg::lim_deg(cfg_q[gsg_pkg::REG_PITCH_MIN]);
    rc_lim.yaw_max   = gsg_pkg::lim_deg(cfg_q[gsg_pkg::REG_YAW_MAX]);
    rc_lim.yaw_min   = gsg_pkg::lim_deg(cfg_q[gsg_pkg::REG_YAW_MIN]);
    pc_lim.pitch_max = gsg_pkg::lim_deg(cfg_q[gsg_pkg::REG_SWEEP_PITCH_MAX]);
    pc_lim.pitch_min = gsg_pkg::lim_deg(cfg_q[gsg_pkg::REG_SWEEP_PITCH_MIN]);
    pc_lim.yaw_max   = gsg_pkg::lim_deg(cfg_q[gsg_pkg::REG_SWEEP_YAW_MAX]);
    pc_lim.yaw_min   = gsg_pkg::lim_deg(cfg_q[gsg_pkg::REG_SWEEP_YAW_MIN]);
  end

  gsg_in_stage u_in_stage (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .advance_i       (advance),
    .valid_o         (s1_valid),
    .item_o          (s1_item)
  );

  // A held tick moves into the result register whenever that register is free or being emptied.
  assign advance = s1_valid && (!out_valid_q || m_axis_tready_i);

  // The first active tick after reset always follows a sleep or debug tick, so it is
  // always a mode change and loads the measured angles; no separate start flag is kept.
  always_comb begin
    rc_tick.changed = (s1_item.mode != prev_mode_q);
    pc_tick.changed = rc_tick.changed;
    rc_tick.en      = advance && (s1_item.mode == gsg_pkg::MODE_RC);
    pc_tick.en      = advance && (s1_item.mode == gsg_pkg::MODE_PC);
  end

  gsg_rc_path u_rc_path (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (rc_tick),
    .item_i  (s1_item),
    .lim_i   (rc_lim),
    .pitch_o (rc_pitch),
    .yaw_o   (rc_yaw)
  );

  gsg_pc_path u_pc_path (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (pc_tick),
    .item_i  (s1_item),
    .lim_i   (pc_lim),
    .pitch_o (pc_pitch),
    .yaw_o   (pc_yaw)
  );

  // Result selection by mode; sleep and debug give zero setpoints with the loop off.
  always_comb begin
    case (s1_item.mode)
      gsg_pkg::MODE_RC: begin
        out_pitch_d = rc_pitch;
        out_yaw_d   = rc_yaw;
        out_sel_d   = gsg_pkg::LOOP_RC;
      end
      gsg_pkg::MODE_PC: begin
        out_pitch_d = pc_pitch;
        out_yaw_d   = pc_yaw;
        out_sel_d   = gsg_pkg::LOOP_PC;
      end
      default: begin
        out_pitch_d = '0;
        out_yaw_d   = '0;
        out_sel_d   = gsg_pkg::LOOP_OFF;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_mode_q <= gsg_pkg::MODE_SLEEP;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      prev_mode_q <= s1_item.mode;
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_pitch_q <= out_pitch_d;
      out_yaw_q   <= out_yaw_d;
      out_sel_q   <= out_sel_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(gsg_pkg::OUT_DATA_W - 2 * gsg_pkg::ANGLE_W){1'b0}},
                            out_yaw_q, out_pitch_q};
  assign m_axis_tuser_o  = out_sel_q;

endmodule

// ===== rtl/core/gsg_in_stage.sv =====
`timescale 1ns / 1ps

module gsg_in_stage (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [gsg_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  input  logic [gsg_pkg::IN_USER_W-1:0]    s_axis_tuser_i,
  input  logic                             advance_i,
  output logic                             valid_o,
  output gsg_pkg::item_t                   item_o
);

  logic           valid_q;
  gsg_pkg::item_t item_d, item_q;

  // The register frees up whenever its contents move on in the same cycle.
  assign s_axis_tready_o = !valid_q || advance_i;

  // Unpack the transfer and form the stick increments ahead of the register.
  always_comb begin
    item_d.mode           = gsg_pkg::mode_e'(s_axis_tuser_i[1:0]);
    item_d.target_locked  = s_axis_tuser_i[2];
    item_d.partner_valid  = s_axis_tuser_i[3];
    item_d.inc_pitch      = gsg_pkg::stick_step(s_axis_tdata_i[21:11], gsg_pkg::GAIN_PITCH);
    // Yaw setpoint moves against the stick.
    item_d.inc_yaw        = -gsg_pkg::stick_step(s_axis_tdata_i[10:0], gsg_pkg::GAIN_YAW);
    item_d.measured_yaw   = s_axis_tdata_i[46:22];
    item_d.measured_pitch = s_axis_tdata_i[71:47];
    item_d.vision_yaw     = s_axis_tdata_i[96:72];
    item_d.vision_pitch   = s_axis_tdata_i[121:97];
    item_d.partner_yaw    = s_axis_tdata_i[146:122];
    item_d.partner_pitch  = s_axis_tdata_i[171:147];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/core/gsg_rc_path.sv =====
`timescale 1ns / 1ps

module gsg_rc_path (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gsg_pkg::tick_t     tick_i,
  input  gsg_pkg::item_t     item_i,
  input  gsg_pkg::limits_t   lim_i,
  output gsg_pkg::angle_t    pitch_o,
  output gsg_pkg::angle_t    yaw_o
);

  gsg_pkg::angle_t pitch_q, yaw_q;
  gsg_pkg::sweep_t pitch_base, yaw_base;

  // A mode change loads the measured angles, otherwise the stick increments integrate.
  always_comb begin
    if (tick_i.changed) begin
      pitch_base = gsg_pkg::widen(item_i.measured_pitch);
      yaw_base   = gsg_pkg::widen(item_i.measured_yaw);
    end else begin
      pitch_base = gsg_pkg::widen(pitch_q) + gsg_pkg::sweep_t'(item_i.inc_pitch);
      yaw_base   = gsg_pkg::widen(yaw_q) + gsg_pkg::sweep_t'(item_i.inc_yaw);
    end
    // The clamped value always lies between two register limits and fits an angle.
    pitch_o = gsg_pkg::angle_t'(gsg_pkg::clamp(pitch_base,
                gsg_pkg::widen(lim_i.pitch_max), gsg_pkg::widen(lim_i.pitch_min)));
    yaw_o   = gsg_pkg::angle_t'(gsg_pkg::clamp(yaw_base,
                gsg_pkg::widen(lim_i.yaw_max), gsg_pkg::widen(lim_i.yaw_min)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q <= '0;
      yaw_q   <= '0;
    end else if (tick_i.en) begin
      pitch_q <= pitch_o;
      yaw_q   <= yaw_o;
    end
  end

endmodule

// ===== rtl/core/gsg_pc_path.sv =====
`timescale 1ns / 1ps

module gsg_pc_path (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gsg_pkg::tick_t     tick_i,
  input  gsg_pkg::item_t     item_i,
  input  gsg_pkg::limits_t   lim_i,
  output gsg_pkg::angle_t    pitch_o,
  output gsg_pkg::angle_t    yaw_o
);

  // With narrow or crossed limits the patrol can keep running one way, so it
  // saturates at the 32-bit range; the working width has one bit to spare so
  // that a step and the reversal compares never wrap.
  gsg_pkg::sweep_t sweep_pitch_q, sweep_pitch_d;
  gsg_pkg::sweep_t sweep_yaw_q, sweep_yaw_d;
  logic            pitch_up_q, pitch_up_d;
  logic            yaw_up_q, yaw_up_d;

  gsg_pkg::sweep_t pmax, pmin, ymax, ymin;
  gsg_pkg::sweep_t pitch_cand, yaw_cand;
  logic            pitch_up_a, yaw_up_a;

  assign pmax = gsg_pkg::widen(lim_i.pitch_max);
  assign pmin = gsg_pkg::widen(lim_i.pitch_min);
  assign ymax = gsg_pkg::widen(lim_i.yaw_max);
  assign ymin = gsg_pkg::widen(lim_i.yaw_min);

  // Patrol direction: turn down near the top, then up near the bottom.
  always_comb begin
    pitch_up_a = pitch_up_q;
    if ((sweep_pitch_q + gsg_pkg::STEP_PITCH >= pmax) && pitch_up_q) begin
      pitch_up_a = 1'b0;
    end
    pitch_up_d = pitch_up_a;
    if ((sweep_pitch_q - gsg_pkg::STEP_PITCH <= pmin) && !pitch_up_a) begin
      pitch_up_d = 1'b1;
    end
    yaw_up_a = yaw_up_q;
    if ((sweep_yaw_q + gsg_pkg::STEP_YAW >= ymax) && yaw_up_q) begin
      yaw_up_a = 1'b0;
    end
    yaw_up_d = yaw_up_a;
    if ((sweep_yaw_q - gsg_pkg::STEP_YAW <= ymin) && !yaw_up_a) begin
      yaw_up_d = 1'b1;
    end
  end

  // Target selection: mode change, vision lock, partner target, then patrol.
  always_comb begin
    sweep_pitch_d = sweep_pitch_q;
    sweep_yaw_d   = sweep_yaw_q;
    if (tick_i.changed) begin
      pitch_cand    = gsg_pkg::widen(item_i.measured_pitch);
      yaw_cand      = gsg_pkg::widen(item_i.measured_yaw);
      sweep_pitch_d = pitch_cand;
      sweep_yaw_d   = yaw_cand;
    end else if (item_i.target_locked) begin
      pitch_cand    = gsg_pkg::widen(item_i.vision_pitch);
      yaw_cand      = gsg_pkg::widen(item_i.vision_yaw);
      sweep_pitch_d = pitch_cand;
      sweep_yaw_d   = gsg_pkg::clamp(yaw_cand, ymax, ymin);
    end else if (item_i.partner_valid) begin
      pitch_cand    = gsg_pkg::widen(item_i.partner_pitch);
      yaw_cand      = gsg_pkg::widen(item_i.partner_yaw);
    end else begin
      sweep_pitch_d = gsg_pkg::clamp(pitch_up_d ? sweep_pitch_q + gsg_pkg::STEP_PITCH
                                                : sweep_pitch_q - gsg_pkg::STEP_PITCH,
                                     gsg_pkg::SWEEP_TOP, gsg_pkg::SWEEP_BOT);
      sweep_yaw_d   = gsg_pkg::clamp(yaw_up_d ? sweep_yaw_q + gsg_pkg::STEP_YAW
                                              : sweep_yaw_q - gsg_pkg::STEP_YAW,
                                     gsg_pkg::SWEEP_TOP, gsg_pkg::SWEEP_BOT);
      pitch_cand    = sweep_pitch_d;
      yaw_cand      = sweep_yaw_d;
    end
    pitch_o = gsg_pkg::angle_t'(gsg_pkg::clamp(pitch_cand, pmax, pmin));
    yaw_o   = gsg_pkg::angle_t'(gsg_pkg::clamp(yaw_cand, ymax, ymin));
  end

  // Direction bits only move on patrol ticks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_pitch_q <= '0;
      sweep_yaw_q   <= '0;
      pitch_up_q    <= 1'b0;
      yaw_up_q      <= 1'b0;
    end else if (tick_i.en) begin
      sweep_pitch_q <= sweep_pitch_d;
      sweep_yaw_q   <= sweep_yaw_d;
      if (!tick_i.changed && !item_i.target_locked && !item_i.partner_valid) begin
        pitch_up_q <= pitch_up_d;
        yaw_up_q   <= yaw_up_d;
      end
    end
  end

endmodule

// ===== rtl/core/gsg_checker.sv =====
`timescale 1ns / 1ps

module gsg_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tready_o,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [gsg_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  input logic [gsg_pkg::OUT_USER_W-1:0]    m_axis_tuser_o
);

  // A stalled result holds still until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // The input side only stalls behind a full, stalled result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output back-pressure");

  // With the drive off both setpoints read zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == gsg_pkg::LOOP_OFF) |-> m_axis_tdata_o == '0)
    else $error("non-zero setpoint with loop off");

  // The padding above the setpoints stays zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      m_axis_tdata_o[gsg_pkg::OUT_DATA_W-1:2*gsg_pkg::ANGLE_W] == '0)
    else $error("result padding not zero");

endmodule

bind gimbal_setpoint_generator gsg_checker u_gsg_checker (.*);

// ===== tb/gimbal_setpoint_generator_tb.sv =====
`timescale 1ns / 1ps

module gimbal_setpoint_generator_tb;
  import gsg_pkg::*;

  // Run length and watchdog.
  localparam int N_DIR           = 24;
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 141;
  localparam int CYCLE_LIMIT     = 300000;

  // Fixed point constants of the setpoint arithmetic.
  localparam longint ANGLE_ONE   = 65536;
  localparam longint STICK_MID   = 1024;
  localparam longint PITCH_GAIN  = 214748;
  localparam longint YAW_GAIN    = 171799;
  localparam longint PITCH_STEP  = 2294;
  localparam longint YAW_STEP    = 1966;
  localparam longint SWEEP_TOP   = 64'sd2147483647;
  localparam longint SWEEP_BOT   = -64'sd2147483648;
  localparam int     ANGLE_LIMIT = 11796480;

  // Angles and sticks used by the directed table.
  localparam angle_t A_TOP  = 25'sd11796480;
  localparam angle_t A_BOT  = -25'sd11796480;
  localparam angle_t A_ZERO = 25'sd0;
  localparam angle_t DEG20  = 25'sd1310720;
  localparam angle_t DEG_M40 = -25'sd2621440;
  localparam angle_t DEG_M60 = -25'sd3932160;
  localparam angle_t DEG65  = 25'sd4259840;
  localparam angle_t DEG_M65 = -25'sd4259840;
  localparam logic [STICK_W-1:0] ST_LO  = 11'd0;
  localparam logic [STICK_W-1:0] ST_MID = 11'd1024;
  localparam logic [STICK_W-1:0] ST_HI  = 11'd2047;

  typedef struct packed {
    mode_e              mode;
    logic               locked;
    logic               partner_ok;
    logic [STICK_W-1:0] stick_yaw;
    logic [STICK_W-1:0] stick_pitch;
    angle_t             meas_yaw;
    angle_t             meas_pitch;
    angle_t             vis_yaw;
    angle_t             vis_pitch;
    angle_t             ptr_yaw;
    angle_t             ptr_pitch;
  } gimbal_tick_t;

  typedef struct packed {
    angle_t    pitch;
    angle_t    yaw;
    loop_sel_e sel;
  } setpoint_t;

  typedef struct packed {
    gimbal_tick_t tick;
    logic         typed;
    setpoint_t    want;
  } tick_row_t;

  localparam setpoint_t UNTYPED = '0;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic [IN_USER_W-1:0]  s_axis_tuser_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [OUT_USER_W-1:0] m_axis_tuser_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [LIM_W-1:0]      cfg_data_i;

  // Idle and stall percentages of the current phase.
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;

  int err_count   = 0;
  int cycle_count = 0;
  int n_off       = 0;
  int n_rc        = 0;
  int n_pc        = 0;

  setpoint_t setpoint_q[$];

  // Predicted block state.
  logic signed [LIM_W-1:0] lim_reg [NUM_REGS];
  mode_e  last_mode;
  logic   active;
  longint rc_pitch, rc_yaw, pc_pitch, pc_yaw, sw_pitch, sw_yaw;
  logic   sw_pitch_up, sw_yaw_up;

  // Directed ticks; an expectation is typed in only where it is obvious.
  tick_row_t dir_rows [N_DIR] = '{
    '{'{MODE_SLEEP, 1'b1, 1'b1, ST_HI, ST_HI, A_TOP, A_TOP, A_TOP, A_TOP, A_TOP, A_TOP},
      1'b1, '{A_ZERO, A_ZERO, LOOP_OFF}},
    '{'{MODE_DEBUG, 1'b0, 1'b0, ST_LO, ST_LO, A_BOT, A_BOT, A_BOT, A_BOT, A_BOT, A_BOT},
      1'b1, '{A_ZERO, A_ZERO, LOOP_OFF}},
    '{'{MODE_RC, 1'b0, 1'b0, ST_MID, ST_MID, A_ZERO, A_ZERO, A_TOP, A_TOP, A_TOP, A_TOP},
      1'b1, '{A_ZERO, A_ZERO, LOOP_RC}},
    '{'{MODE_RC, 1'b1, 1'b0, ST_LO, ST_HI, A_TOP, A_TOP, A_BOT, A_BOT, A_BOT, A_BOT},
      1'b0, UNTYPED},
    '{'{MODE_RC, 1'b0, 1'b1, ST_HI, ST_LO, A_BOT, A_BOT, A_TOP, A_TOP, A_TOP, A_TOP},
      1'b0, UNTYPED},
    '{'{MODE_RC, 1'b0, 1'b0, 11'd1023, 11'd1025, A_ZERO, A_ZERO, A_ZERO, A_ZERO, A_ZERO,
        A_ZERO}, 1'b0, UNTYPED},
    '{'{MODE_SLEEP, 1'b0, 1'b0, ST_MID, ST_MID, A_ZERO, A_ZERO, A_ZERO, A_ZERO, A_ZERO,
        A_ZERO}, 1'b1, '{A_ZERO, A_ZERO, LOOP_OFF}},
    '{'{MODE_RC, 1'b0, 1'b0, ST_MID, ST_MID, A_BOT, A_TOP, A_ZERO, A_ZERO, A_ZERO, A_ZERO},
      1'b1, '{DEG20, DEG_M60, LOOP_RC}},
    '{'{MODE_RC, 1'b0, 1'b0, ST_HI, ST_HI, A_ZERO, A_ZERO, A_ZERO, A_ZERO, A_ZERO, A_ZERO},
      1'b1, '{DEG20, DEG_M60, LOOP_RC}},
    '{'{MODE_PC, 1'b0, 1'b0, ST_MID, ST_MID, A_TOP, A_BOT, A_ZERO, A_ZERO, A_ZERO, A_ZERO},
      1'b1, '{DEG_M40, DEG65, LOOP_PC}},
    '{'{MODE_PC, 1'b0, 1'b0, ST_LO, ST_HI, A_ZERO, A_ZERO, A_ZERO, A_ZERO, A_ZERO, A_ZERO},
      1'b0, UNTYPED},
    '{'{MODE_PC, 1'b0, 1'b0, ST_HI, ST_LO, A_ZERO, A_ZERO, A_ZERO, A_ZERO, A_ZERO, A_ZERO},
      1'b0, UNTYPED},
    '{'{MODE_PC, 1'b0, 1'b0, ST_MID, ST_MID, A_BOT, A_TOP, A_ZERO, A_ZERO, A_ZERO, A_ZERO},
      1'b0, UNTYPED},
    '{'{MODE_PC, 1'b1, 1'b0, ST_MID, ST_MID, A_ZERO, A_ZERO, A_BOT, A_TOP, A_ZERO, A_ZERO},
      1'b1, '{DEG20, DEG_M65, LOOP_PC}},
    '{'{MODE_PC, 1'b0, 1'b0, ST_MID, ST_MID, A_ZERO, A_ZERO, A_ZERO, A_ZERO, A_ZERO, A_ZERO},
      1'b0, UNTYPED},
    '{'{MODE_PC, 1'b0, 1'b0, ST_MID, ST_MID, A_ZERO, A_ZERO, A_ZERO, A_ZERO, A_ZERO, A_ZERO},
      1'b0, UNTYPED},
    '{'{MODE_PC, 1'b0, 1'b1, ST_MID, ST_MID, A_ZERO, A_ZERO, A_ZERO, A_ZERO, -25'sd654321,
        25'sd123456}, 1'b0, UNTYPED},
    '{'{MODE_PC, 1'b1, 1'b1, ST_MID, ST_MID, A_ZERO, A_ZERO, 25'sd300000, -25'sd200000,
        A_TOP, A_BOT}, 1'b0, UNTYPED},
    '{'{MODE_DEBUG, 1'b1, 1'b1, ST_HI, ST_LO, A_TOP, A_BOT, A_TOP, A_BOT, A_TOP, A_BOT},
      1'b1, '{A_ZERO, A_ZERO, LOOP_OFF}},
    '{'{MODE_PC, 1'b0, 1'b0, ST_MID, ST_MID, 25'sd70000, -25'sd90000, A_ZERO, A_ZERO,
        A_ZERO, A_ZERO}, 1'b0, UNTYPED},
    '{'{MODE_PC, 1'b0, 1'b0, ST_MID, ST_MID, A_ZERO, A_ZERO, A_ZERO, A_ZERO, A_ZERO, A_ZERO},
      1'b0, UNTYPED},
    '{'{MODE_RC, 1'b0, 1'b0, ST_MID, ST_MID, -25'sd500000, 25'sd400000, A_ZERO, A_ZERO,
        A_ZERO, A_ZERO}, 1'b0, UNTYPED},
    '{'{MODE_RC, 1'b1, 1'b1, ST_MID, ST_MID, A_ZERO, A_ZERO, A_ZERO, A_ZERO, A_ZERO, A_ZERO},
      1'b0, UNTYPED},
    '{'{MODE_SLEEP, 1'b1, 1'b0, ST_LO, ST_HI, A_BOT, A_TOP, A_ZERO, A_ZERO, A_ZERO, A_ZERO},
      1'b1, '{A_ZERO, A_ZERO, LOOP_OFF}}
  };

  gimbal_setpoint_generator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Limit x to [mn, mx]; when the two cross, x >= mx gives mx and any other x gives mn.
  function automatic longint clip(longint x, longint mx, longint mn);
    if (x >= mx) return mx;
    if (x <= mn) return mn;
    return x;
  endfunction

  // Drop 16 fraction bits, rounding to nearest with ties away from zero.
  function automatic longint round_q16(longint p);
    if (p >= 0) return (p + 32768) / 65536;
    return -((-p + 32768) / 65536);
  endfunction

  function automatic longint deg_units(reg_idx_e r);
    return longint'(lim_reg[r]) * ANGLE_ONE;
  endfunction

  function automatic void clear_prediction();
    for (int i = 0; i < NUM_REGS; i++) lim_reg[i] = REG_RESET[i];
    last_mode   = MODE_SLEEP;
    active      = 1'b0;
    rc_pitch    = 0;
    rc_yaw      = 0;
    pc_pitch    = 0;
    pc_yaw      = 0;
    sw_pitch    = 0;
    sw_yaw      = 0;
    sw_pitch_up = 1'b0;
    sw_yaw_up   = 1'b0;
  endfunction

  // Advance the predicted state by one tick and return the setpoints it yields.
  function automatic setpoint_t advance_setpoints(gimbal_tick_t t);
    setpoint_t r;
    logic      fresh;
    longint    dy, dp, pmax, pmin, ymax, ymin;
    fresh     = (t.mode != last_mode);
    last_mode = t.mode;
    r         = UNTYPED;
    dy        = longint'(t.stick_yaw) - STICK_MID;
    dp        = longint'(t.stick_pitch) - STICK_MID;
    case (t.mode)
      MODE_RC: begin
        if (!active) begin
          rc_pitch = 0;
          rc_yaw   = 0;
          active   = 1'b1;
        end
        if (fresh) begin
          rc_yaw   = longint'(t.meas_yaw);
          rc_pitch = longint'(t.meas_pitch);
        end else begin
          rc_yaw   -= round_q16(dy * YAW_GAIN);
          rc_pitch += round_q16(dp * PITCH_GAIN);
        end
        rc_pitch = clip(rc_pitch, deg_units(REG_PITCH_MAX), deg_units(REG_PITCH_MIN));
        rc_yaw   = clip(rc_yaw, deg_units(REG_YAW_MAX), deg_units(REG_YAW_MIN));
        r.pitch  = angle_t'(rc_pitch);
        r.yaw    = angle_t'(rc_yaw);
        r.sel    = LOOP_RC;
      end
      MODE_PC: begin
        pmax = deg_units(REG_SWEEP_PITCH_MAX);
        pmin = deg_units(REG_SWEEP_PITCH_MIN);
        ymax = deg_units(REG_SWEEP_YAW_MAX);
        ymin = deg_units(REG_SWEEP_YAW_MIN);
        if (!active) begin
          pc_pitch = 0;
          pc_yaw   = 0;
          sw_pitch = 0;
          sw_yaw   = 0;
          active   = 1'b1;
        end
        if (fresh) begin
          pc_pitch = longint'(t.meas_pitch);
          pc_yaw   = longint'(t.meas_yaw);
          sw_pitch = pc_pitch;
          sw_yaw   = pc_yaw;
        end else if (t.locked) begin
          pc_pitch = longint'(t.vis_pitch);
          pc_yaw   = longint'(t.vis_yaw);
          sw_pitch = pc_pitch;
          sw_yaw   = clip(pc_yaw, ymax, ymin);
        end else if (t.partner_ok) begin
          pc_pitch = longint'(t.ptr_pitch);
          pc_yaw   = longint'(t.ptr_yaw);
        end else begin
          // Triangle patrol: reverse near either limit, then take one step.
          if (sw_pitch + PITCH_STEP >= pmax && sw_pitch_up) sw_pitch_up = 1'b0;
          if (sw_pitch - PITCH_STEP <= pmin && !sw_pitch_up) sw_pitch_up = 1'b1;
          if (sw_yaw + YAW_STEP >= ymax && sw_yaw_up) sw_yaw_up = 1'b0;
          if (sw_yaw - YAW_STEP <= ymin && !sw_yaw_up) sw_yaw_up = 1'b1;
          sw_pitch = clip(sw_pitch + (sw_pitch_up ? PITCH_STEP : -PITCH_STEP),
                          SWEEP_TOP, SWEEP_BOT);
          sw_yaw   = clip(sw_yaw + (sw_yaw_up ? YAW_STEP : -YAW_STEP), SWEEP_TOP, SWEEP_BOT);
          pc_pitch = sw_pitch;
          pc_yaw   = sw_yaw;
        end
        pc_pitch = clip(pc_pitch, pmax, pmin);
        pc_yaw   = clip(pc_yaw, ymax, ymin);
        r.pitch  = angle_t'(pc_pitch);
        r.yaw    = angle_t'(pc_yaw);
        r.sel    = LOOP_PC;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    err_count++;
  endtask

  // Offer one tick on the input side and record its expectation once transferred.
  task automatic send_tick(gimbal_tick_t t, logic typed, setpoint_t want);
    setpoint_t predicted;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {4'b0, t.ptr_pitch, t.ptr_yaw, t.vis_pitch, t.vis_yaw,
                       t.meas_pitch, t.meas_yaw, t.stick_pitch, t.stick_yaw};
    s_axis_tuser_i  = {t.partner_ok, t.locked, t.mode};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = advance_setpoints(t);
    setpoint_q.push_back(typed ? want : predicted);
  endtask

  // Hold the input side off until every expected setpoint has arrived.
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (setpoint_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_limit(reg_idx_e idx, int deg);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = LIM_W'(deg);
    do @(posedge clk_i); while (!cfg_ready_o);
    lim_reg[idx] = cfg_data_i;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_limits(int p_hi, int p_lo, int y_hi, int y_lo,
                            int sp_hi, int sp_lo, int sy_hi, int sy_lo);
    write_limit(REG_PITCH_MAX, p_hi);
    write_limit(REG_PITCH_MIN, p_lo);
    write_limit(REG_YAW_MAX, y_hi);
    write_limit(REG_YAW_MIN, y_lo);
    write_limit(REG_SWEEP_PITCH_MAX, sp_hi);
    write_limit(REG_SWEEP_PITCH_MIN, sp_lo);
    write_limit(REG_SWEEP_YAW_MAX, sy_hi);
    write_limit(REG_SWEEP_YAW_MIN, sy_lo);
  endtask

  function automatic int rand_hi();
    return int'($urandom_range(180));
  endfunction

  function automatic int rand_lo();
    return -int'($urandom_range(180));
  endfunction

  function automatic mode_e pick_mode();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return MODE_SLEEP;
    if (r < 18) return MODE_DEBUG;
    if (r < 55) return MODE_RC;
    return MODE_PC;
  endfunction

  function automatic logic [STICK_W-1:0] rand_stick();
    case ($urandom_range(3))
      0:       return STICK_W'($urandom_range(2047));
      1:       return $urandom_range(1) ? ST_HI : ST_LO;
      default: return STICK_W'($urandom_range(1032, 1016));
    endcase
  endfunction

  // Angles: anywhere, near zero, close to one of the current limits, or at the extremes.
  function automatic angle_t rand_angle();
    int v;
    case ($urandom_range(3))
      0: v = int'($urandom_range(2 * ANGLE_LIMIT)) - ANGLE_LIMIT;
      1: v = int'($urandom_range(393216)) - 196608;
      2: v = int'(lim_reg[$urandom_range(NUM_REGS - 1)]) * 65536
             + int'($urandom_range(16384)) - 8192;
      default: v = $urandom_range(1) ? ANGLE_LIMIT : -ANGLE_LIMIT;
    endcase
    if (v > ANGLE_LIMIT) v = ANGLE_LIMIT;
    if (v < -ANGLE_LIMIT) v = -ANGLE_LIMIT;
    return angle_t'(v);
  endfunction

  function automatic gimbal_tick_t rand_tick(mode_e m);
    gimbal_tick_t t;
    t.mode = m;
    if (m == MODE_PC) begin
      // Mostly patrol, with occasional vision lock or partner target.
      t.locked     = ($urandom_range(99) < 15);
      t.partner_ok = ($urandom_range(99) < 25);
    end else begin
      t.locked     = 1'($urandom_range(1));
      t.partner_ok = 1'($urandom_range(1));
    end
    t.stick_yaw   = rand_stick();
    t.stick_pitch = rand_stick();
    t.meas_yaw    = rand_angle();
    t.meas_pitch  = rand_angle();
    t.vis_yaw     = rand_angle();
    t.vis_pitch   = rand_angle();
    t.ptr_yaw     = rand_angle();
    t.ptr_pitch   = rand_angle();
    return t;
  endfunction

  // Runs of one mode so that integration and patrol get going, with some stray ticks.
  task automatic run_random(int n_items);
    int           sent;
    int           run_len;
    int           k;
    mode_e        m;
    gimbal_tick_t t;
    sent = 0;
    while (sent < n_items) begin
      m       = pick_mode();
      run_len = $urandom_range(60, 1);
      k       = 0;
      while (k < run_len && sent < n_items) begin
        t = rand_tick(($urandom_range(99) < 8) ? pick_mode() : m);
        send_tick(t, 1'b0, UNTYPED);
        if ($urandom_range(199) == 0) wait_drained();
        k++;
        sent++;
      end
    end
  endtask

  // Receiver back-pressure.
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready_i = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Compare each result transfer with the oldest expected setpoint.
  always @(posedge clk_i) begin
    setpoint_t got;
    setpoint_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.pitch = m_axis_tdata_o[ANGLE_W-1:0];
      got.yaw   = m_axis_tdata_o[2*ANGLE_W-1:ANGLE_W];
      got.sel   = loop_sel_e'(m_axis_tuser_o);
      if (setpoint_q.size() == 0) begin
        report_mismatch("result transfer with no setpoint expected");
      end else begin
        want = setpoint_q.pop_front();
        if (got.pitch !== want.pitch)
          report_mismatch($sformatf("pitch %0d, expected %0d", got.pitch, want.pitch));
        if (got.yaw !== want.yaw)
          report_mismatch($sformatf("yaw %0d, expected %0d", got.yaw, want.yaw));
        if (got.sel !== want.sel)
          report_mismatch($sformatf("loop select %0d, expected %0d", got.sel, want.sel));
        if (want.sel == LOOP_RC) n_rc++;
        else if (want.sel == LOOP_PC) n_pc++;
        else n_off++;
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d setpoints outstanding", cycle_count,
             setpoint_q.size());
    $display("DONE: errors detected");
    $finish;
  end

  // Main sequence.
  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = REG_PITCH_MAX;
    cfg_data_i      = '0;
    clear_prediction();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table at the default limits.
    for (int i = 0; i < N_DIR; i++) begin
      send_tick(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases over several limit settings and idle profiles.
    for (int phase = 0; phase < N_PHASES; phase++) begin
      case (phase % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 50; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 50; end
        default: begin src_idle_pct = 33; sink_stall_pct = 33; end
      endcase
      if (phase != 0) begin
        wait_drained();
        repeat (4) @(negedge clk_i);
        case (phase)
          1: set_limits(180, -180, 180, -180, 180, -180, 180, -180);
          2: set_limits(-180, 180, -180, 180, -180, 180, -180, 180);
          3: set_limits(1, -1, 2, -2, 1, -1, 1, -1);
          4: set_limits(0, 0, 0, 0, 0, 0, 0, 0);
          default: set_limits(rand_hi(), rand_lo(), rand_hi(), rand_lo(),
                              rand_hi(), rand_lo(), rand_hi(), rand_lo());
        endcase
      end
      run_random(ITEMS_PER_PHASE);
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("Checked %0d setpoint transfers: %0d drive off, %0d RC loop, %0d PC loop.",
             n_off + n_rc + n_pc, n_off, n_rc, n_pc);
    $display("Limits: defaults, widest, crossed, tight, zero and random; four idle profiles.");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== gimbal_setpoint_generator.f =====
rtl/core/gsg_pkg.sv
rtl/core/gsg_in_stage.sv
rtl/core/gsg_rc_path.sv
rtl/core/gsg_pc_path.sv
rtl/core/gimbal_setpoint_generator.sv
rtl/core/gsg_checker.sv
tb/gimbal_setpoint_generator_tb.sv
